/* hw/rtl/lbc_pkg.sv */
// Package for the LRU block buffer cache manager.
// Holds sizes, operation and status codes, the sequencer states and shared structs.
// No dependencies.
package lbc_pkg;

   localparam int ENTRIES      = 64;
   localparam int SECTOR_WIDTH = 64;
   localparam int COUNT_WIDTH  = 16;
   localparam int IDX_W        = $clog2(ENTRIES);
   localparam int CNT_W        = $clog2(ENTRIES + 1);
   localparam int CFG_W        = 7;

   // operation kinds
   localparam logic [2:0] KIND_GET        = 3'd0;
   localparam logic [2:0] KIND_RELEASE    = 3'd1;
   localparam logic [2:0] KIND_REL_DIRTY  = 3'd2;
   localparam logic [2:0] KIND_MARK_DIRTY = 3'd3;
   localparam logic [2:0] KIND_MARK_CLEAN = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_OOM       = 2'd1;
   localparam logic [1:0] STAT_UNDERFLOW = 2'd2;
   localparam logic [1:0] STAT_NOT_USED  = 2'd3;

   // entry states
   localparam logic [1:0] ST_UNREAD = 2'd0;
   localparam logic [1:0] ST_CLEAN  = 2'd1;
   localparam logic [1:0] ST_DIRTY  = 2'd2;

   // slot roles
   localparam logic [1:0] ROLE_UNUSED = 2'd0;
   localparam logic [1:0] ROLE_LRU    = 2'd1;
   localparam logic [1:0] ROLE_FREE   = 2'd2;

   // csr register indexes
   localparam logic CSR_LRU_LIMIT   = 1'b0;
   localparam logic CSR_PURGE_BATCH = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_OP_RD, S_OP_WR, S_LK_RANK, S_LK_TAG, S_LK_CMP,
      S_SH_RD, S_SH_WR, S_SH_END, S_MISS, S_POP, S_ALLOC,
      S_PG_RANK, S_PG_ENT, S_PG_DEC, S_PG_POP
   } state_type;

   typedef struct packed {
      logic [CFG_W-1:0] lru_limit;
      logic [CFG_W-1:0] purge_batch;
   } cfg_type;

   typedef struct packed {
      logic                   valid;
      logic [IDX_W-1:0]       slot;
      logic                   hit;
      logic [1:0]             status;
      logic [COUNT_WIDTH-1:0] ref_count;
      logic [1:0]             entry_state;
      logic [CNT_W-1:0]       dirty_total;
   } rsp_type;

endpackage

/* hw/rtl/lbc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

/* hw/rtl/lbc_ctrl.sv */
// Sequencer and datapath of the cache manager: walks the LRU order through the
// rank and tag RAMs with one shared compare. Uses lbc_pkg and lbc_ram.
module lbc_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [2:0]                     kind,
   input  logic [lbc_pkg::SECTOR_WIDTH-1:0] sector,
   input  logic [lbc_pkg::IDX_W-1:0]      entry,
   input  lbc_pkg::cfg_type               cfg,
   output lbc_pkg::rsp_type               rsp
);
   import lbc_pkg::*;

   state_type state_ff, state_in;

   logic [2:0]              kind_ff, kind_in;
   logic [SECTOR_WIDTH-1:0] sector_ff, sector_in;
   logic [IDX_W-1:0]        ent_ff, ent_in;
   logic [IDX_W-1:0]        e_ff, e_in;
   logic [CNT_W-1:0]        i_ff, i_in;
   logic [CNT_W-1:0]        kept_ff, kept_in;
   logic [CNT_W-1:0]        moved_ff, moved_in;
   logic [CNT_W-1:0]        lru_cnt_ff, lru_cnt_in;
   logic [CNT_W-1:0]        free_cnt_ff, free_cnt_in;
   logic [IDX_W-1:0]        free_head_ff, free_head_in;
   logic [CNT_W-1:0]        dirty_ff, dirty_in;
   logic [CNT_W-1:0]        next_unused_ff, next_unused_in;
   rsp_type                 rsp_ff, rsp_in;

   // slot roles live in a RAM; slots at or above next_unused read as unused
   logic                   role_we, role_re;
   logic [IDX_W-1:0]       role_waddr, role_raddr;
   logic [1:0]             role_wdata, role_rdata;

   // RAM ports
   logic                    rank_we, rank_re, tag_we, tag_re;
   logic                    rc_we, rc_re, st_we, st_re, fq_we, fq_re;
   logic [IDX_W-1:0]        rank_waddr, rank_raddr, tag_waddr, tag_raddr;
   logic [IDX_W-1:0]        rc_waddr, rc_raddr, st_waddr, st_raddr;
   logic [IDX_W-1:0]        fq_waddr, fq_raddr;
   logic [IDX_W-1:0]        rank_wdata, rank_rdata, fq_wdata, fq_rdata;
   logic [SECTOR_WIDTH-1:0] tag_wdata, tag_rdata;
   logic [COUNT_WIDTH-1:0]  rc_wdata, rc_rdata;
   logic [1:0]              st_wdata, st_rdata;

   lbc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank (
      .clock(clock), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
      .re(rank_re), .raddr(rank_raddr), .rdata(rank_rdata));
   lbc_ram #(.WIDTH(SECTOR_WIDTH), .DEPTH(ENTRIES)) u_tag (
      .clock(clock), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
      .re(tag_re), .raddr(tag_raddr), .rdata(tag_rdata));
   lbc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ENTRIES)) u_rc (
      .clock(clock), .we(rc_we), .waddr(rc_waddr), .wdata(rc_wdata),
      .re(rc_re), .raddr(rc_raddr), .rdata(rc_rdata));
   lbc_ram #(.WIDTH(2), .DEPTH(ENTRIES)) u_st (
      .clock(clock), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
      .re(st_re), .raddr(st_raddr), .rdata(st_rdata));
   lbc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_fq (
      .clock(clock), .we(fq_we), .waddr(fq_waddr), .wdata(fq_wdata),
      .re(fq_re), .raddr(fq_raddr), .rdata(fq_rdata));
   lbc_ram #(.WIDTH(2), .DEPTH(ENTRIES)) u_role (
      .clock(clock), .we(role_we), .waddr(role_waddr), .wdata(role_wdata),
      .re(role_re), .raddr(role_raddr), .rdata(role_rdata));

   // shared conditions
   logic accept, kind_ok, tag_match, scan_done, shift_done, eligible, batch_ok;
   logic can_unused, ent_in_lru;
   logic [CNT_W-1:0] j_plus;

   assign accept     = start && (state_ff == S_IDLE);
   assign kind_ok    = (kind <= KIND_MARK_CLEAN);
   assign tag_match  = (tag_rdata == sector_ff);
   assign scan_done  = (i_ff >= lru_cnt_ff);
   assign j_plus     = i_ff + CNT_W'(1);
   assign shift_done = (j_plus >= lru_cnt_ff);
   assign batch_ok   = (cfg.purge_batch == '0) || (moved_ff < cfg.purge_batch);
   assign eligible   = batch_ok && (rc_rdata == '0) && (st_rdata == ST_CLEAN);
   assign can_unused = (lru_cnt_ff < cfg.lru_limit) && (next_unused_ff < CNT_W'(ENTRIES));
   assign ent_in_lru = ({1'b0, ent_ff} < next_unused_ff) && (role_rdata == ROLE_LRU);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && kind_ok) begin
               state_in = (kind == KIND_GET) ? S_LK_RANK : S_OP_RD;
            end
         end
         S_OP_RD:   state_in = ent_in_lru ? S_OP_WR : S_IDLE;
         S_OP_WR:   state_in = S_IDLE;
         S_LK_RANK: state_in = scan_done ? S_MISS : S_LK_TAG;
         S_LK_TAG:  state_in = S_LK_CMP;
         S_LK_CMP:  state_in = tag_match ? S_SH_RD : S_LK_RANK;
         S_SH_RD:   state_in = shift_done ? S_SH_END : S_SH_WR;
         S_SH_WR:   state_in = S_SH_RD;
         S_SH_END:  state_in = S_IDLE;
         S_MISS: begin
            if (free_cnt_ff != '0) begin
               state_in = S_POP;
            end else if (can_unused) begin
               state_in = S_ALLOC;
            end else begin
               state_in = S_PG_RANK;
            end
         end
         S_POP:     state_in = S_ALLOC;
         S_ALLOC:   state_in = S_IDLE;
         S_PG_RANK: state_in = scan_done ? S_PG_POP : S_PG_ENT;
         S_PG_ENT:  state_in = S_PG_DEC;
         S_PG_DEC:  state_in = S_PG_RANK;
         S_PG_POP:  state_in = (free_cnt_ff != '0) ? S_POP : S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath, RAM controls and result word
   logic [COUNT_WIDTH-1:0] rc_new;
   logic [1:0]             st_new;
   logic [1:0]             stat_new;
   logic [CNT_W-1:0]       dirty_new;

   always_comb begin
      kind_in        = kind_ff;
      sector_in      = sector_ff;
      ent_in         = ent_ff;
      e_in           = e_ff;
      i_in           = i_ff;
      kept_in        = kept_ff;
      moved_in       = moved_ff;
      lru_cnt_in     = lru_cnt_ff;
      free_cnt_in    = free_cnt_ff;
      free_head_in   = free_head_ff;
      dirty_in       = dirty_ff;
      next_unused_in = next_unused_ff;
      rsp_in         = rsp_ff;
      rsp_in.valid   = 1'b0;
      role_we = 1'b0; role_waddr = e_ff; role_wdata = ROLE_LRU;
      role_re = 1'b0; role_raddr = entry;
      rank_we = 1'b0; rank_waddr = i_ff[IDX_W-1:0]; rank_wdata = e_ff;
      rank_re = 1'b0; rank_raddr = i_ff[IDX_W-1:0];
      tag_we  = 1'b0; tag_waddr = e_ff; tag_wdata = sector_ff;
      tag_re  = 1'b0; tag_raddr = rank_rdata;
      rc_we   = 1'b0; rc_waddr = e_ff; rc_wdata = COUNT_WIDTH'(1);
      rc_re   = 1'b0; rc_raddr = e_ff;
      st_we   = 1'b0; st_waddr = e_ff; st_wdata = ST_UNREAD;
      st_re   = 1'b0; st_raddr = e_ff;
      fq_we   = 1'b0; fq_waddr = free_head_ff + free_cnt_ff[IDX_W-1:0]; fq_wdata = e_ff;
      fq_re   = 1'b0; fq_raddr = free_head_ff;
      rc_new    = rc_rdata;
      st_new    = st_rdata;
      stat_new  = STAT_OK;
      dirty_new = dirty_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in   = kind;
               sector_in = sector;
               ent_in    = entry;
               i_in      = '0;
               role_re   = 1'b1;
            end
         end
         S_OP_RD: begin
            rc_re = 1'b1; rc_raddr = ent_ff;
            st_re = 1'b1; st_raddr = ent_ff;
            if (!ent_in_lru) begin
               rsp_in.valid       = 1'b1;
               rsp_in.slot        = ent_ff;
               rsp_in.hit         = 1'b0;
               rsp_in.status      = STAT_NOT_USED;
               rsp_in.ref_count   = '0;
               rsp_in.entry_state = ST_UNREAD;
               rsp_in.dirty_total = dirty_ff;
            end
         end
         S_OP_WR: begin
            // dirty marking
            if (kind_ff == KIND_REL_DIRTY || kind_ff == KIND_MARK_DIRTY) begin
               if (st_rdata != ST_DIRTY) begin
                  dirty_new = dirty_ff + CNT_W'(1);
               end
               st_new = ST_DIRTY;
            end
            if (kind_ff == KIND_MARK_CLEAN) begin
               if (st_rdata == ST_DIRTY && dirty_ff != '0) begin
                  dirty_new = dirty_ff - CNT_W'(1);
               end
               st_new = ST_CLEAN;
            end
            // release
            if (kind_ff == KIND_RELEASE || kind_ff == KIND_REL_DIRTY) begin
               if (rc_rdata == '0) begin
                  stat_new = STAT_UNDERFLOW;
               end else begin
                  rc_new = rc_rdata - COUNT_WIDTH'(1);
               end
            end
            rc_we = 1'b1; rc_waddr = ent_ff; rc_wdata = rc_new;
            st_we = 1'b1; st_waddr = ent_ff; st_wdata = st_new;
            dirty_in           = dirty_new;
            rsp_in.valid       = 1'b1;
            rsp_in.slot        = ent_ff;
            rsp_in.hit         = 1'b0;
            rsp_in.status      = stat_new;
            rsp_in.ref_count   = rc_new;
            rsp_in.entry_state = st_new;
            rsp_in.dirty_total = dirty_new;
         end
         S_LK_RANK: begin
            rank_re = !scan_done;
         end
         S_LK_TAG: begin
            e_in   = rank_rdata;
            tag_re = 1'b1;
         end
         S_LK_CMP: begin
            if (tag_match) begin
               rc_re = 1'b1;
               st_re = 1'b1;
            end else begin
               i_in = i_ff + CNT_W'(1);
            end
         end
         // close the gap left by the hit entry
         S_SH_RD: begin
            rank_re    = !shift_done;
            rank_raddr = j_plus[IDX_W-1:0];
         end
         S_SH_WR: begin
            rank_we    = 1'b1;
            rank_wdata = rank_rdata;
            i_in       = j_plus;
         end
         S_SH_END: begin
            rank_we = 1'b1;
            rc_new  = (rc_rdata == {COUNT_WIDTH{1'b1}}) ? rc_rdata
                                                        : rc_rdata + COUNT_WIDTH'(1);
            rc_we    = 1'b1;
            rc_wdata = rc_new;
            rsp_in.valid       = 1'b1;
            rsp_in.slot        = e_ff;
            rsp_in.hit         = 1'b1;
            rsp_in.status      = STAT_OK;
            rsp_in.ref_count   = rc_new;
            rsp_in.entry_state = st_rdata;
            rsp_in.dirty_total = dirty_ff;
         end
         S_MISS: begin
            if (free_cnt_ff != '0) begin
               fq_re = 1'b1;
            end else if (can_unused) begin
               e_in           = next_unused_ff[IDX_W-1:0];
               next_unused_in = next_unused_ff + CNT_W'(1);
            end else begin
               i_in     = '0;
               kept_in  = '0;
               moved_in = '0;
            end
         end
         S_POP: begin
            e_in         = fq_rdata;
            free_head_in = free_head_ff + IDX_W'(1);
            free_cnt_in  = free_cnt_ff - CNT_W'(1);
         end
         S_ALLOC: begin
            tag_we  = 1'b1;
            rc_we   = 1'b1;
            st_we   = 1'b1;
            role_we = 1'b1;
            if (lru_cnt_ff < CNT_W'(ENTRIES)) begin
               rank_we    = 1'b1;
               rank_waddr = lru_cnt_ff[IDX_W-1:0];
               lru_cnt_in = lru_cnt_ff + CNT_W'(1);
            end
            rsp_in.valid       = 1'b1;
            rsp_in.slot        = e_ff;
            rsp_in.hit         = 1'b0;
            rsp_in.status      = STAT_OK;
            rsp_in.ref_count   = COUNT_WIDTH'(1);
            rsp_in.entry_state = ST_UNREAD;
            rsp_in.dirty_total = dirty_ff;
         end
         // purge pass: compact kept entries, push freed ones
         S_PG_RANK: begin
            rank_re = !scan_done;
            if (scan_done) begin
               lru_cnt_in = kept_ff;
            end
         end
         S_PG_ENT: begin
            e_in     = rank_rdata;
            rc_re    = 1'b1; rc_raddr = rank_rdata;
            st_re    = 1'b1; st_raddr = rank_rdata;
         end
         S_PG_DEC: begin
            if (eligible) begin
               fq_we       = 1'b1;
               free_cnt_in = free_cnt_ff + CNT_W'(1);
               role_we     = 1'b1;
               role_wdata  = ROLE_FREE;
               moved_in    = moved_ff + CNT_W'(1);
            end else begin
               rank_we    = 1'b1;
               rank_waddr = kept_ff[IDX_W-1:0];
               kept_in    = kept_ff + CNT_W'(1);
            end
            i_in = i_ff + CNT_W'(1);
         end
         S_PG_POP: begin
            if (free_cnt_ff != '0) begin
               fq_re = 1'b1;
            end else begin
               rsp_in.valid       = 1'b1;
               rsp_in.slot        = '0;
               rsp_in.hit         = 1'b0;
               rsp_in.status      = STAT_OOM;
               rsp_in.ref_count   = '0;
               rsp_in.entry_state = ST_UNREAD;
               rsp_in.dirty_total = dirty_ff;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         lru_cnt_ff     <= '0;
         free_cnt_ff    <= '0;
         free_head_ff   <= '0;
         dirty_ff       <= '0;
         next_unused_ff <= '0;
         rsp_ff.valid   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         lru_cnt_ff     <= lru_cnt_in;
         free_cnt_ff    <= free_cnt_in;
         free_head_ff   <= free_head_in;
         dirty_ff       <= dirty_in;
         next_unused_ff <= next_unused_in;
         rsp_ff.valid   <= rsp_in.valid;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff            <= kind_in;
      sector_ff          <= sector_in;
      ent_ff             <= ent_in;
      e_ff               <= e_in;
      i_ff               <= i_in;
      kept_ff            <= kept_in;
      moved_ff           <= moved_in;
      rsp_ff.slot        <= rsp_in.slot;
      rsp_ff.hit         <= rsp_in.hit;
      rsp_ff.status      <= rsp_in.status;
      rsp_ff.ref_count   <= rsp_in.ref_count;
      rsp_ff.entry_state <= rsp_in.entry_state;
      rsp_ff.dirty_total <= rsp_in.dirty_total;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp  = rsp_ff;

   // checks
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid |-> (state_ff == S_IDLE))
      else $error("result strobe outside idle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && kind <= KIND_MARK_CLEAN) |=> busy)
      else $error("accepted word did not start the sequencer");
   // a purge pass grows the free count before the LRU count shrinks
   a_slots: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |->
         (({1'b0, lru_cnt_ff} + {1'b0, free_cnt_ff}) <= {1'b0, next_unused_ff}))
      else $error("LRU and free counts exceed slots handed out");
   a_dirty: assert property (@(posedge clock) disable iff (reset)
      dirty_ff <= CNT_W'(ENTRIES))
      else $error("dirty count out of range");
endmodule

/* hw/rtl/lru_block_buffer_cache_manager.sv */
// Top level of the LRU block buffer cache manager: csr registers and ports.
// Uses lbc_pkg and lbc_ctrl.
//
//  channel | ports                                   | handshake
//  req     | req_kind, req_sector, req_entry         | start & !busy
//  rsp     | rsp_slot .. rsp_dirty_total             | rsp_valid strobe, one cycle
//  csr     | csr_index, csr_wdata                    | csr_valid & csr_ready
//
// Release and mark words pass a read and a write state (only the read state
// when the entry is not in use). A get scans the LRU order with a rank RAM
// read, a tag RAM read and a tag compare per entry; a hit shifts each younger
// entry down to close the gap, a miss pops the free queue, takes a never-used
// slot or purges, reading every LRU entry through the single read ports.
// Reset is synchronous, clears the counters and sets the csr registers to
// their defaults; slots at or above the never-used mark read as unused.
// The receiver cannot stall: each result is shown for exactly one cycle.
module lru_block_buffer_cache_manager (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [2:0]                         req_kind,
   input  logic [lbc_pkg::SECTOR_WIDTH-1:0]   req_sector,
   input  logic [lbc_pkg::IDX_W-1:0]          req_entry,
   output logic                               rsp_valid,
   output logic [lbc_pkg::IDX_W-1:0]          rsp_slot,
   output logic                               rsp_hit,
   output logic [1:0]                         rsp_status,
   output logic [lbc_pkg::COUNT_WIDTH-1:0]    rsp_ref_count,
   output logic [1:0]                         rsp_entry_state,
   output logic [lbc_pkg::CNT_W-1:0]          rsp_dirty_total,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_index,
   input  logic [lbc_pkg::CFG_W-1:0]          csr_wdata
);
   import lbc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   rsp_type rsp;

   // csr writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LRU_LIMIT:   cfg_in.lru_limit   = csr_wdata;
            CSR_PURGE_BATCH: cfg_in.purge_batch = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lru_limit   <= CFG_W'(64);
         cfg_ff.purge_batch <= CFG_W'(6);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   lbc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .kind   (req_kind),
      .sector (req_sector),
      .entry  (req_entry),
      .cfg    (cfg_ff),
      .rsp    (rsp)
   );

   assign rsp_valid       = rsp.valid;
   assign rsp_slot        = rsp.slot;
   assign rsp_hit         = rsp.hit;
   assign rsp_status      = rsp.status;
   assign rsp_ref_count   = rsp.ref_count;
   assign rsp_entry_state = rsp.entry_state;
   assign rsp_dirty_total = rsp.dirty_total;
endmodule

/* bench/lru_block_buffer_cache_manager_test.sv */
// Testbench for the LRU block buffer cache manager: directed and random words
// checked field by field against an in-bench prediction of tags, LRU and counts.
// Depends on lbc_pkg and lru_block_buffer_cache_manager.
`timescale 1ns / 1ps

module lru_block_buffer_cache_manager_test;
   import lbc_pkg::*;

   localparam int WATCH_LIMIT = 20000;
   localparam int TAIL_CYCLES = 800;

   typedef struct packed {
      logic [IDX_W-1:0]       slot;
      logic                   hit;
      logic [1:0]             status;
      logic [COUNT_WIDTH-1:0] ref_count;
      logic [1:0]             entry_state;
      logic [CNT_W-1:0]       dirty_total;
   } cache_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [2:0]              req_kind = '0;
   logic [SECTOR_WIDTH-1:0] req_sector = '0;
   logic [IDX_W-1:0]        req_entry = '0;
   logic                    rsp_valid;
   logic [IDX_W-1:0]        rsp_slot;
   logic                    rsp_hit;
   logic [1:0]              rsp_status;
   logic [COUNT_WIDTH-1:0]  rsp_ref_count;
   logic [1:0]              rsp_entry_state;
   logic [CNT_W-1:0]        rsp_dirty_total;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic                    csr_index = 1'b0;
   logic [CFG_W-1:0]        csr_wdata = '0;

   lru_block_buffer_cache_manager i_dut (.*);

   always #2 clock = ~clock;

   // predicted cache state
   logic [SECTOR_WIDTH-1:0] tag_of [ENTRIES];
   logic [1:0]              role_of [ENTRIES];
   logic [COUNT_WIDTH-1:0]  refs_of [ENTRIES];
   logic [1:0]              state_of [ENTRIES];
   int                      lru_order [ENTRIES];
   int                      free_ring [ENTRIES];
   int                      free_head, lru_len, free_len, dirty_len, fresh_next;
   int                      limit_cfg, batch_cfg;

   cache_word_type expected_words [$];
   int  mismatches, words_seen, items_sent, hits_seen, oom_seen, under_seen, unused_seen;
   int  quiet_cycles;
   bit  allow_idle;

   // model of one purge pass: eligible entries go to the free ring, oldest first
   function automatic void purge_clean();
      int kept, moved, e;
      kept = 0;
      moved = 0;
      for (int i = 0; i < lru_len; i++) begin
         e = lru_order[i];
         if ((batch_cfg == 0 || moved < batch_cfg) && refs_of[e] == 0 &&
             state_of[e] == ST_CLEAN) begin
            free_ring[(free_head + free_len) % ENTRIES] = e;
            free_len++;
            role_of[e] = ROLE_FREE;
            moved++;
         end else begin
            lru_order[kept++] = e;
         end
      end
      lru_len = kept;
   endfunction

   function automatic bit pop_free(output int e);
      if (free_len == 0) return 1'b0;
      e = free_ring[free_head];
      free_head = (free_head + 1) % ENTRIES;
      free_len--;
      return 1'b1;
   endfunction

   function automatic void to_dirty(int e);
      if (state_of[e] != ST_DIRTY) dirty_len++;
      state_of[e] = ST_DIRTY;
   endfunction

   // predict the word for one accepted request; returns 0 for unknown kinds
   function automatic bit predict_word(logic [2:0] kind, logic [SECTOR_WIDTH-1:0] sector,
                                       logic [IDX_W-1:0] ent, output cache_word_type w);
      int e;
      logic [1:0] stat;
      w = '0;
      stat = STAT_OK;
      if (kind == KIND_GET) begin
         for (int i = 0; i < lru_len; i++) begin
            e = lru_order[i];
            if (tag_of[e] == sector) begin
               if (refs_of[e] != '1) refs_of[e]++;
               for (int j = i; j < lru_len - 1; j++) lru_order[j] = lru_order[j + 1];
               lru_order[lru_len - 1] = e;
               w.slot = IDX_W'(e); w.hit = 1'b1; w.ref_count = refs_of[e];
               w.entry_state = state_of[e]; w.dirty_total = CNT_W'(dirty_len);
               return 1'b1;
            end
         end
         if (!pop_free(e)) begin
            if (lru_len < limit_cfg && fresh_next < ENTRIES) begin
               e = fresh_next++;
            end else begin
               purge_clean();
               if (!pop_free(e)) begin
                  w.status = STAT_OOM; w.dirty_total = CNT_W'(dirty_len);
                  return 1'b1;
               end
            end
         end
         tag_of[e] = sector; refs_of[e] = COUNT_WIDTH'(1); state_of[e] = ST_UNREAD;
         role_of[e] = ROLE_LRU;
         lru_order[lru_len++] = e;
         w.slot = IDX_W'(e); w.ref_count = COUNT_WIDTH'(1); w.entry_state = ST_UNREAD;
         w.dirty_total = CNT_W'(dirty_len);
         return 1'b1;
      end
      if (kind > KIND_MARK_CLEAN) return 1'b0;
      w.slot = ent;
      if (role_of[ent] != ROLE_LRU) begin
         w.status = STAT_NOT_USED; w.dirty_total = CNT_W'(dirty_len);
         return 1'b1;
      end
      case (kind)
         KIND_RELEASE, KIND_REL_DIRTY: begin
            if (kind == KIND_REL_DIRTY) to_dirty(ent);
            if (refs_of[ent] == 0) stat = STAT_UNDERFLOW;
            else refs_of[ent]--;
         end
         KIND_MARK_DIRTY: to_dirty(ent);
         default: begin
            if (state_of[ent] == ST_DIRTY && dirty_len > 0) dirty_len--;
            state_of[ent] = ST_CLEAN;
         end
      endcase
      w.status = stat; w.ref_count = refs_of[ent];
      w.entry_state = state_of[ent]; w.dirty_total = CNT_W'(dirty_len);
      return 1'b1;
   endfunction

   // send one request word; it is accepted at a rising edge with start and not busy
   task automatic send_word(logic [2:0] kind, logic [SECTOR_WIDTH-1:0] sector,
                            logic [IDX_W-1:0] ent);
      cache_word_type w;
      @(negedge clock);
      start <= 1'b1;
      req_kind <= kind;
      req_sector <= sector;
      req_entry <= ent;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      items_sent++;
      if (predict_word(kind, sector, ent, w)) expected_words.push_back(w);
   endtask

   task automatic idle_burst();
      if (allow_idle && $urandom_range(3) == 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(17)) @(negedge clock);
      end
   endtask

   // wait until every expected word is back, plus margin for ignored kinds
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      if (idx == CSR_LRU_LIMIT) limit_cfg = int'(value);
      else batch_cfg = int'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(int limit, int batch);
      drain();
      write_csr(CSR_LRU_LIMIT, CFG_W'(limit));
      write_csr(CSR_PURGE_BATCH, CFG_W'(batch));
   endtask

   // check each result word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         cache_word_type got, want;
         got = '{rsp_slot, rsp_hit, rsp_status, rsp_ref_count, rsp_entry_state,
                 rsp_dirty_total};
         words_seen++;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: %p", got);
         end else begin
            want = expected_words.pop_front();
            if (want.hit) hits_seen++;
            if (want.status == STAT_OOM) oom_seen++;
            if (want.status == STAT_UNDERFLOW) under_seen++;
            if (want.status == STAT_NOT_USED) unused_seen++;
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
            end
         end
      end
   end

   // watchdog on cycles without any accepted word, result word or csr write
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCH_LIMIT) begin
         $display("watchdog expired");
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [IDX_W-1:0] pick_entry();
      if (lru_len > 0 && $urandom_range(3) != 0)
         return IDX_W'(lru_order[$urandom_range(lru_len - 1)]);
      return IDX_W'($urandom_range(ENTRIES - 1));
   endfunction

   function automatic logic [SECTOR_WIDTH-1:0] pick_sector(int pool);
      case ($urandom_range(9))
         0: return {$urandom, $urandom};
         1: return {$urandom, 32'hFFFF_FFFF} ^ {32'h0, $urandom_range(pool)};
         default: return SECTOR_WIDTH'($urandom_range(pool));
      endcase
   endfunction

   // every kind, sector extremes, underflow, not in use and ignored kinds
   task automatic test_single_ops();
      send_word(KIND_GET, '0, '0);
      send_word(KIND_GET, '1, '1);
      send_word(KIND_GET, '1, '0);
      send_word(KIND_RELEASE, '0, 6'd1);
      send_word(KIND_RELEASE, '0, 6'd1);
      send_word(KIND_REL_DIRTY, '1, 6'd1);
      send_word(KIND_MARK_DIRTY, '0, 6'd0);
      send_word(KIND_MARK_CLEAN, '0, 6'd0);
      send_word(KIND_MARK_CLEAN, '0, 6'd1);
      send_word(KIND_RELEASE, '0, '1);
      send_word(3'd7, '1, '1);
      send_word(3'd5, '0, '0);
      send_word(KIND_GET, 64'h5555_5555_5555_5555, 6'd42);
   endtask

   // tiny limit: out of memory, then purge and reuse through the free queue
   task automatic test_purge_and_oom();
      set_config(2, 1);
      send_word(KIND_GET, 64'd100, '0);
      send_word(KIND_GET, 64'd101, '0);
      send_word(KIND_GET, 64'd102, '0);
      send_word(KIND_RELEASE, '0, IDX_W'(lru_order[0]));
      send_word(KIND_MARK_CLEAN, '0, IDX_W'(lru_order[0]));
      send_word(KIND_RELEASE, '0, IDX_W'(lru_order[1]));
      send_word(KIND_MARK_CLEAN, '0, IDX_W'(lru_order[1]));
      send_word(KIND_GET, 64'd103, '0);
      send_word(KIND_MARK_DIRTY, '0, IDX_W'(free_len > 0 ? free_ring[free_head] : 0));
      send_word(KIND_GET, 64'd104, '0);
   endtask

   // random phase: gets on a sector pool mixed with releases, marks and some ignored kinds
   task automatic test_random_phase(int count, int pool, bit do_pause);
      int roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 40)
            send_word(KIND_GET, pick_sector(pool), IDX_W'($urandom));
         else if (roll < 62)
            send_word(KIND_RELEASE, SECTOR_WIDTH'($urandom), pick_entry());
         else if (roll < 70)
            send_word(KIND_REL_DIRTY, SECTOR_WIDTH'($urandom), pick_entry());
         else if (roll < 78)
            send_word(KIND_MARK_DIRTY, SECTOR_WIDTH'($urandom), pick_entry());
         else if (roll < 96)
            send_word(KIND_MARK_CLEAN, SECTOR_WIDTH'($urandom), pick_entry());
         else
            send_word(3'($urandom_range(7, 5)), SECTOR_WIDTH'($urandom), IDX_W'($urandom));
         if (do_pause && n == count / 2) drain();
         idle_burst();
      end
   endtask

   initial begin
      mismatches = 0; words_seen = 0; items_sent = 0; hits_seen = 0;
      oom_seen = 0; under_seen = 0; unused_seen = 0; quiet_cycles = 0;
      free_head = 0; lru_len = 0; free_len = 0; dirty_len = 0; fresh_next = 0;
      limit_cfg = 64; batch_cfg = 6;
      allow_idle = 1'b1;
      foreach (role_of[i]) role_of[i] = ROLE_UNUSED;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_single_ops();
      test_purge_and_oom();
      set_config(64, 64);
      test_random_phase(250, 90, 1'b1);
      set_config(8, 3);
      test_random_phase(200, 20, 1'b0);
      set_config(127, 0);
      test_random_phase(200, 120, 1'b0);
      set_config(1, 1);
      test_random_phase(150, 10, 1'b0);
      set_config(0, 2);
      test_random_phase(150, 40, 1'b0);
      set_config(16, 6);
      allow_idle = 1'b0;
      test_random_phase(300, 30, 1'b0);

      drain();
      $display("sent %0d words, checked %0d results: %0d hits, %0d out of memory,",
               items_sent, words_seen, hits_seen, oom_seen);
      $display("%0d underflows, %0d not in use, %0d mismatches",
               under_seen, unused_seen, mismatches);
      if (mismatches == 0 && expected_words.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/lbc_pkg.sv
hw/rtl/lbc_ram.sv
hw/rtl/lbc_ctrl.sv
hw/rtl/lru_block_buffer_cache_manager.sv
bench/lru_block_buffer_cache_manager_test.sv
